/* rtl/mdic_pkg.sv */
package mdic_pkg;
	localparam int MAX_INTERVALS = 1024;
	localparam int IDX_W = $clog2(MAX_INTERVALS);
	localparam int CNT_W = IDX_W + 1;
	localparam int VAL_W = 32;
	localparam int IV_W = 2 * VAL_W;
	localparam int PRED_DEPTH = MAX_INTERVALS + 1;
endpackage

/* rtl/max_disjoint_interval_cover.sv */
// Insertion shifts larger entries up one place at a time; on the last item a binary
// predecessor search runs for each interval and then the cover pass, both paced by
// the single read port of each memory.
// One item is worked at a time; a new item is taken once the previous one is done.
// Reset (arst_n, asynchronous) empties the set, clears the overflow flag and line_length.
module max_disjoint_interval_cover (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] interval_start,
	input  logic [31:0] interval_end,
	input  logic        last_interval,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] uncovered_count,
	output logic        capacity_overflow
);
	import mdic_pkg::*;

	logic [VAL_W-1:0] line_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= '0;
		end else if (cfg_we) begin
			line_length_q <= cfg_wdata;
		end
	end

	mdic_ctrl u_ctrl (
		.clk, .arst_n, .line_length(line_length_q),
		.interval_start, .interval_end, .last_interval,
		.in_valid, .in_ready, .uncovered_count, .capacity_overflow,
		.out_valid, .out_ready);
endmodule

/* rtl/mdic_ram.sv */
module mdic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/mdic_ctrl.sv */
module mdic_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mdic_pkg::VAL_W-1:0] line_length,
	input  logic [mdic_pkg::VAL_W-1:0] interval_start,
	input  logic [mdic_pkg::VAL_W-1:0] interval_end,
	input  logic                      last_interval,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic [mdic_pkg::VAL_W-1:0] uncovered_count,
	output logic                      capacity_overflow,
	output logic                      out_valid,
	input  logic                      out_ready
);
	import mdic_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_PR_RD, S_PR_SRD, S_PR_BRD, S_PR_BCMP,
		S_DP_RD, S_DP_RD2, S_DP_CALC, S_OUT
	} state_t;

	state_t state_q;
	logic [VAL_W-1:0] s_q, e_q, ss_q, prev_q;
	logic [VAL_W:0] len_q;
	logic last_q, ovf_q;
	logic [CNT_W-1:0] cnt_q, pos_q, i_q, lo_q, hi_q, ans_q;

	// Interval store: {start, end}.
	logic iv_we;
	logic [IDX_W-1:0] iv_waddr, iv_raddr;
	logic [IV_W-1:0] iv_wdata, iv_rdata;
	mdic_ram #(.WIDTH(IV_W), .DEPTH(MAX_INTERVALS)) u_iv (
		.clk, .we(iv_we), .waddr(iv_waddr), .wdata(iv_wdata),
		.raddr(iv_raddr), .rdata(iv_rdata));

	logic pr_we;
	logic [CNT_W-1:0] pr_waddr, pr_raddr;
	logic [CNT_W-1:0] pr_wdata, pr_rdata;
	mdic_ram #(.WIDTH(CNT_W), .DEPTH(PRED_DEPTH)) u_pr (
		.clk, .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
		.raddr(pr_raddr), .rdata(pr_rdata));

	logic bc_we;
	logic [CNT_W-1:0] bc_waddr, bc_raddr;
	logic [VAL_W-1:0] bc_wdata, bc_rdata;
	mdic_ram #(.WIDTH(VAL_W), .DEPTH(PRED_DEPTH)) u_bc (
		.clk, .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
		.raddr(bc_raddr), .rdata(bc_rdata));

	logic [VAL_W-1:0] rd_s, rd_e;
	assign rd_s = iv_rdata[IV_W-1:VAL_W];
	assign rd_e = iv_rdata[VAL_W-1:0];

	logic [CNT_W-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// An interval may span the whole 32-bit range, so its length needs one more bit.
	logic [VAL_W:0] take;
	logic [VAL_W-1:0] take_sat, best;
	assign take = len_q + {1'b0, bc_rdata};
	assign take_sat = take[VAL_W] ? '1 : take[VAL_W-1:0];
	assign best = (take_sat > prev_q) ? take_sat : prev_q;

	// At position zero there is nothing left below to move up.
	logic shift;
	assign shift = (pos_q != '0) && ((rd_e > e_q) || ((rd_e == e_q) && (rd_s > s_q)));

	always_comb begin
		iv_we = 1'b0;
		iv_waddr = pos_q[IDX_W-1:0];
		iv_wdata = {s_q, e_q};
		iv_raddr = pos_q[IDX_W-1:0] - 1'b1;
		pr_we = 1'b0;
		pr_waddr = i_q;
		pr_wdata = ans_q;
		pr_raddr = i_q;
		bc_we = 1'b0;
		bc_waddr = i_q;
		bc_wdata = best;
		bc_raddr = pr_rdata;
		case (state_q)
			S_INS_CMP: begin
				iv_we = 1'b1;
				if (shift) begin
					iv_wdata = iv_rdata;
				end
			end
			S_PR_RD: iv_raddr = i_q[IDX_W-1:0] - 1'b1;
			S_PR_BRD: iv_raddr = mid[IDX_W-1:0] - 1'b1;
			S_PR_BCMP: begin
				iv_raddr = mid[IDX_W-1:0] - 1'b1;
				pr_we = (lo_q > hi_q);
			end
			S_DP_RD: iv_raddr = i_q[IDX_W-1:0] - 1'b1;
			S_DP_CALC: bc_we = 1'b1;
			default: ;
		endcase
		if (state_q == S_IDLE) begin
			bc_we = 1'b1;
			bc_waddr = '0;
			bc_wdata = '0;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					s_q <= interval_start;
					e_q <= interval_end;
					last_q <= last_interval;
					pos_q <= cnt_q;
					i_q <= CNT_W'(1);
					if (interval_start <= interval_end && cnt_q < CNT_W'(MAX_INTERVALS)) begin
						state_q <= (cnt_q == '0) ? S_INS_CMP : S_INS_RD;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						if (interval_start <= interval_end) ovf_q <= 1'b1;
						state_q <= last_interval ? S_PR_RD : S_IDLE;
					end
				end
				S_INS_RD: state_q <= S_INS_CMP;
				S_INS_CMP: begin
					// The shifted entry was written at pos; move down one place.
					if (shift && pos_q > CNT_W'(1)) begin
						pos_q <= pos_q - 1'b1;
						state_q <= S_INS_RD;
					end else if (shift) begin
						pos_q <= '0;
						state_q <= S_INS_CMP;
					end else begin
						state_q <= last_q ? S_PR_RD : S_IDLE;
					end
				end
				S_PR_RD: begin
					if (i_q > cnt_q) begin
						i_q <= CNT_W'(1);
						prev_q <= '0;
						state_q <= (cnt_q == '0) ? S_OUT : S_DP_RD;
					end else begin
						state_q <= S_PR_SRD;
					end
				end
				S_PR_SRD: begin
					ss_q <= rd_s;
					lo_q <= CNT_W'(1);
					hi_q <= cnt_q;
					ans_q <= '0;
					state_q <= S_PR_BRD;
				end
				S_PR_BRD: state_q <= S_PR_BCMP;
				S_PR_BCMP: begin
					if (lo_q > hi_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_PR_RD;
					end else begin
						if (rd_e < ss_q) begin
							ans_q <= mid;
							lo_q <= mid + 1'b1;
						end else begin
							hi_q <= mid - 1'b1;
						end
						state_q <= S_PR_BRD;
					end
				end
				S_DP_RD: state_q <= S_DP_RD2;
				S_DP_RD2: begin
					len_q <= {1'b0, rd_e} - {1'b0, rd_s} + (VAL_W + 1)'(1);
					state_q <= S_DP_CALC;
				end
				S_DP_CALC: begin
					prev_q <= best;
					i_q <= i_q + 1'b1;
					state_q <= (i_q >= cnt_q) ? S_OUT : S_DP_RD;
				end
				S_OUT: if (out_ready) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		uncovered_count = (line_length > prev_q) ? line_length - prev_q : '0;
		if (cnt_q == '0) uncovered_count = line_length;
		capacity_overflow = ovf_q;
	end
endmodule

/* test/max_disjoint_interval_cover_checker.sv */
module max_disjoint_interval_cover_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] interval_start,
	input  logic [31:0] interval_end,
	input  logic        last_interval,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] uncovered_count,
	input  logic        capacity_overflow,
	output int          mismatches,
	output int          pending,
	output int          checked,
	output int          overflow_sets
);
	timeunit 1ns;
	timeprecision 1ps;
	import mdic_pkg::*;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] e;
	} span_t;

	typedef struct packed {
		logic [31:0] uncovered;
		logic        overflow;
	} cover_result_t;

	span_t         spans[$];
	logic          dropped;
	logic [31:0]   line_len;
	cover_result_t expected_covers[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Keeps spans ordered by end, then start; equal pairs keep arrival order.
	function automatic void add_span(input logic [31:0] s, input logic [31:0] e);
		int pos;
		pos = spans.size();
		while (pos > 0 && (spans[pos-1].e > e || (spans[pos-1].e == e && spans[pos-1].s > s)))
			pos--;
		spans.insert(pos, '{s: s, e: e});
	endfunction

	function automatic logic [31:0] best_cover();
		int          n;
		int          lo, hi, mid, prev;
		longint      best[];
		longint      take, skip;
		n = spans.size();
		best = new[n + 1];
		best[0] = 0;
		for (int i = 1; i <= n; i++) begin
			// Latest span that ends strictly before this one starts.
			lo = 1;
			hi = n;
			prev = 0;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (spans[mid-1].e < spans[i-1].s) begin
					prev = mid;
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			take = longint'(spans[i-1].e) - longint'(spans[i-1].s) + 1 + best[prev];
			skip = best[i-1];
			best[i] = take > skip ? take : skip;
			if (best[i] > 64'hFFFF_FFFF)
				best[i] = 64'hFFFF_FFFF;
		end
		return best[n][31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cover_result_t r;
		logic [31:0]   cover_len;
		if (!arst_n) begin
			spans.delete();
			expected_covers.delete();
			dropped = 1'b0;
			line_len = '0;
			mismatches = 0;
			checked = 0;
			overflow_sets = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (interval_start <= interval_end) begin
					if (spans.size() < MAX_INTERVALS)
						add_span(interval_start, interval_end);
					else
						dropped = 1'b1;
				end
				if (last_interval) begin
					cover_len = best_cover();
					r.uncovered = line_len > cover_len ? line_len - cover_len : '0;
					r.overflow = dropped;
					if (dropped)
						overflow_sets++;
					expected_covers.insert(expected_covers.size(), r);
					spans.delete();
					dropped = 1'b0;
				end
			end
			if (cfg_we)
				line_len = cfg_wdata;
			if (out_valid && out_ready) begin
				if (expected_covers.size() == 0) begin
					report("unexpected result", uncovered_count, '0);
				end else begin
					r = expected_covers[0];
					expected_covers.delete(0);
					if (uncovered_count !== r.uncovered)
						report("uncovered_count", uncovered_count, r.uncovered);
					if (capacity_overflow !== r.overflow)
						report("capacity_overflow", 32'(capacity_overflow), 32'(r.overflow));
					checked++;
				end
			end
		end
		pending = expected_covers.size();
	end
endmodule

/* test/max_disjoint_interval_cover_tb.sv */
module max_disjoint_interval_cover_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] interval_start = '0;
	logic [31:0] interval_end = '0;
	logic        last_interval = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] uncovered_count;
	logic        capacity_overflow;
	int          mismatches, pending, checked, overflow_sets;
	int          items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	max_disjoint_interval_cover DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .interval_start(interval_start),
		.interval_end(interval_end), .last_interval(last_interval),
		.out_valid(out_valid), .out_ready(out_ready),
		.uncovered_count(uncovered_count), .capacity_overflow(capacity_overflow)
	);

	max_disjoint_interval_cover_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .interval_start(interval_start),
		.interval_end(interval_end), .last_interval(last_interval),
		.out_valid(out_valid), .out_ready(out_ready),
		.uncovered_count(uncovered_count), .capacity_overflow(capacity_overflow),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.overflow_sets(overflow_sets)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Valid stays high across back-to-back items; it drops only when a gap follows.
	task automatic send_interval(input logic [31:0] s, input logic [31:0] e, input logic last,
			input bit idle = 1'b1);
		int gap;
		in_valid <= 1'b1;
		interval_start <= s;
		interval_end <= e;
		last_interval <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		gap = idle ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle_and_write(input logic [31:0] len);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_set(input int n);
		int          mode;
		logic [31:0] s, e, t;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: begin
					s = $urandom_range(0, 63);
					e = s + $urandom_range(0, 12);
				end
				1: begin
					s = $urandom;
					e = $urandom;
				end
				2: begin
					s = 32'hFFFF_FF00 + $urandom_range(0, 255);
					e = 32'hFFFF_FF00 + $urandom_range(0, 255);
				end
				default: begin
					s = $urandom_range(0, 400);
					e = s + $urandom_range(0, 60);
				end
			endcase
			// Mostly well-formed; a few reversed ones get through unswapped.
			if (s > e && $urandom_range(0, 3) != 0) begin
				t = s;
				s = e;
				e = t;
			end
			send_interval(s, e, i == n - 1);
		end
	endtask

	// Receiver alternates ready runs with stalls, now and then a long clean run.
	initial begin
		int run, stall;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
			stall = pick_gap();
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] lengths[5];
		lengths = '{32'd0, 32'hFFFF_FFFF, 32'd200, 32'd64, 32'h8000_0000};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty set before any write: line length is still zero.
		send_interval(32'd5, 32'd1, 1'b1);
		settle_and_write(32'hFFFF_FFFF);
		send_interval(32'd0, 32'hFFFF_FFFF, 1'b1);
		send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_interval(32'd0, 32'd0, 1'b0);
		send_interval(32'hFFFF_FFFF, 32'd0, 1'b1);
		send_interval(32'd9, 32'd3, 1'b1);
		send_interval(32'd0, 32'h7FFF_FFFF, 1'b0);
		send_interval(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_interval(32'd10, 32'd20, 1'b1);
		settle_and_write(32'd100);
		// Touching ends are not disjoint; equal ends with differing starts.
		send_interval(32'd10, 32'd20, 1'b0);
		send_interval(32'd20, 32'd30, 1'b0);
		send_interval(32'd5, 32'd30, 1'b0);
		send_interval(32'd21, 32'd30, 1'b0);
		send_interval(32'd0, 32'd9, 1'b1);
		send_interval(32'd40, 32'd200, 1'b0);
		send_interval(32'd3, 32'd4, 1'b1);
		send_interval(32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0);
		send_interval(32'h5555_5555, 32'h5555_5555, 1'b1);

		for (int p = 0; p < 5; p++) begin
			settle_and_write(lengths[p] == 32'h8000_0000 ? $urandom : lengths[p]);
			for (int k = 0; k < 20; k++) begin
				random_set($urandom_range(0, 7) == 0 ? $urandom_range(8, 16)
					: $urandom_range(1, 4));
				if (k == 10) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d intervals; checked %0d cover results, %0d with capacity overflow.",
			items_sent, checked, overflow_sets);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

/* filelist.f */
rtl/mdic_pkg.sv
rtl/mdic_ram.sv
rtl/mdic_ctrl.sv
rtl/max_disjoint_interval_cover.sv
test/max_disjoint_interval_cover_checker.sv
test/max_disjoint_interval_cover_tb.sv
